// ===== rtl/mfp_pkg.sv =====
// Shared types, constants and helper functions for the mesh frame parser.
package mfp_pkg;

  localparam int PAYLOAD_MAX = 128;
  localparam int PATH_MAX    = 8;
  localparam int FIELD_BYTES = 20;
  localparam int HDR_BYTES   = FIELD_BYTES + 2 * PATH_MAX;
  localparam int POS_W       = 9;
  localparam int POS_SAT     = (1 << POS_W) - 1;
  localparam int SUM_W       = POS_W + 1;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam int FIFO_DEPTH  = 8;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW     = FIFO_AW + 1;
  localparam int ADMIT_LIMIT = FIFO_DEPTH - 4;

  localparam logic [1:0] KIND_FIELD   = 2'd0;
  localparam logic [1:0] KIND_PATH    = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_VERDICT = 2'd3;

  localparam logic [2:0] VERDICT_OK        = 3'd0;
  localparam logic [2:0] VERDICT_SHORT_HDR = 3'd1;
  localparam logic [2:0] VERDICT_PLEN_BIG  = 3'd2;
  localparam logic [2:0] VERDICT_PATH_BIG  = 3'd3;
  localparam logic [2:0] VERDICT_SHORT_PAY = 3'd4;
  localparam logic [2:0] VERDICT_CRC_BAD   = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  index;
    logic [31:0] value;
    logic [2:0]  verdict;
    logic        last;
  } result_t;

  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  typedef struct packed {
    logic [7:0] idx;
    logic [1:0] lane;
    logic       first;
    logic       fin;
  } fld_info_t;

  // Header field layout by byte offset.
  function automatic fld_info_t fld_info(input logic [4:0] pos);
    fld_info_t f;
    f = '0;
    case (pos)
      5'd0:  f = '{idx: 8'd0,  lane: 2'd0, first: 1'b1, fin: 1'b0};
      5'd1:  f = '{idx: 8'd0,  lane: 2'd1, first: 1'b0, fin: 1'b0};
      5'd2:  f = '{idx: 8'd0,  lane: 2'd2, first: 1'b0, fin: 1'b0};
      5'd3:  f = '{idx: 8'd0,  lane: 2'd3, first: 1'b0, fin: 1'b1};
      5'd4:  f = '{idx: 8'd1,  lane: 2'd0, first: 1'b1, fin: 1'b0};
      5'd5:  f = '{idx: 8'd1,  lane: 2'd1, first: 1'b0, fin: 1'b1};
      5'd6:  f = '{idx: 8'd2,  lane: 2'd0, first: 1'b1, fin: 1'b0};
      5'd7:  f = '{idx: 8'd2,  lane: 2'd1, first: 1'b0, fin: 1'b1};
      5'd8:  f = '{idx: 8'd3,  lane: 2'd0, first: 1'b1, fin: 1'b0};
      5'd9:  f = '{idx: 8'd3,  lane: 2'd1, first: 1'b0, fin: 1'b1};
      5'd10: f = '{idx: 8'd4,  lane: 2'd0, first: 1'b1, fin: 1'b0};
      5'd11: f = '{idx: 8'd4,  lane: 2'd1, first: 1'b0, fin: 1'b1};
      5'd12: f = '{idx: 8'd5,  lane: 2'd0, first: 1'b1, fin: 1'b1};
      5'd13: f = '{idx: 8'd6,  lane: 2'd0, first: 1'b1, fin: 1'b1};
      5'd14: f = '{idx: 8'd7,  lane: 2'd0, first: 1'b1, fin: 1'b0};
      5'd15: f = '{idx: 8'd7,  lane: 2'd1, first: 1'b0, fin: 1'b1};
      5'd16: f = '{idx: 8'd8,  lane: 2'd0, first: 1'b1, fin: 1'b1};
      5'd17: f = '{idx: 8'd9,  lane: 2'd0, first: 1'b1, fin: 1'b1};
      5'd18: f = '{idx: 8'd10, lane: 2'd0, first: 1'b1, fin: 1'b1};
      5'd19: f = '{idx: 8'd11, lane: 2'd0, first: 1'b1, fin: 1'b1};
      default: f = '0;
    endcase
    return f;
  endfunction

  // CRC-16/CCITT-FALSE, one byte, MSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/mesh_frame_parser_crc16_check_top.sv =====
// Top level of the mesh frame parser with CRC-16 check.
// An accepted byte's words pass the input register, then the output queue.
// Throughput: one byte per cycle; a frame-end byte adds a verdict result word, and the
// output queue (8 words) holds off input while queued words plus 2 for a byte in
// flight exceed 4.
// Reset: synchronous, active high; clears parse state, CRC to 0xFFFF and the queue.
// After a frame-end byte the parser returns to its reset state by itself.
module mesh_frame_parser_crc16_check_top
  import mfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  data_byte,
  input  logic        frame_end,
  output logic        item_valid,
  input  logic        item_ready,
  output logic [1:0]  item_kind,
  output logic [7:0]  item_index,
  output logic [31:0] item_value,
  output logic [2:0]  verdict,
  output logic        last_item
);

  logic               busy;
  push_t              push;
  logic [FIFO_CW-1:0] count;
  logic [FIFO_CW-1:0] reserved;
  result_t            head;
  logic               accept;

  assign reserved   = count + (busy ? FIFO_CW'(2) : FIFO_CW'(0));
  assign byte_ready = (reserved <= FIFO_CW'(ADMIT_LIMIT));
  assign accept     = byte_valid & byte_ready;

  mfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .busy      (busy),
    .push      (push)
  );

  mfp_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .count      (count),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .head       (head)
  );

  assign item_kind  = head.kind;
  assign item_index = head.index;
  assign item_value = head.value;
  assign verdict    = head.verdict;
  assign last_item  = head.last;

endmodule

// ===== rtl/mfp_parse.sv =====
// Frame byte decoder: input register, parse state, CRC and verdict logic.
module mfp_parse
  import mfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output logic       busy,
  output push_t      push
);

  logic             s_valid;
  logic [7:0]       s_byte;
  logic             s_fend;

  logic [POS_W-1:0] pos, pos_next;
  logic [15:0]      crc, crc_next;
  logic [31:0]      acc, acc_next;
  logic [7:0]       plen_seen, plen_next;
  logic [7:0]       pcnt_seen, pcnt_next;
  logic [15:0]      rcrc, rcrc_next;

  logic [SUM_W-1:0] pos_ext, crc_end, len, r_full, pay_idx;
  logic [7:0]       plen_eff;
  fld_info_t        info;
  logic [31:0]      acc_base;
  logic [2:0]       vcode;
  result_t          item;
  logic             have_item;
  result_t          vitem;

  assign busy = s_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
    end
    if (accept) begin
      s_byte <= data_byte;
      s_fend <= frame_end;
    end
  end

  always_comb begin
    pos_ext   = {1'b0, pos};
    plen_eff  = (pos == POS_W'(FIELD_BYTES - 2)) ? s_byte : plen_seen;
    crc_end   = SUM_W'(HDR_BYTES) + {{(SUM_W-8){1'b0}}, plen_eff};
    len       = pos_ext + SUM_W'(1);
    r_full    = pos_ext - SUM_W'(FIELD_BYTES);
    pay_idx   = pos_ext - SUM_W'(HDR_BYTES);
    info      = fld_info(pos[4:0]);
    acc_base  = info.first ? 32'd0 : acc;

    pos_next  = pos;
    crc_next  = crc;
    acc_next  = acc;
    plen_next = plen_seen;
    pcnt_next = pcnt_seen;
    rcrc_next = rcrc;
    item      = '0;
    have_item = 1'b0;
    vitem     = '0;
    vcode     = VERDICT_OK;

    if (s_valid) begin
      if (pos < POS_W'(FIELD_BYTES)) begin
        acc_next = acc_base | ({24'd0, s_byte} << {info.lane, 3'b000});
        if (info.fin) begin
          have_item  = 1'b1;
          item.kind  = KIND_FIELD;
          item.index = info.idx;
          item.value = acc_next;
        end
        if (pos == POS_W'(FIELD_BYTES - 2)) begin
          plen_next = s_byte;
        end
        if (pos == POS_W'(FIELD_BYTES - 1)) begin
          pcnt_next = s_byte;
        end
      end else if (pos < POS_W'(HDR_BYTES)) begin
        if (!r_full[0]) begin
          acc_next = {24'd0, s_byte};
        end else begin
          acc_next   = acc | {16'd0, s_byte, 8'd0};
          have_item  = 1'b1;
          item.kind  = KIND_PATH;
          item.index = r_full[8:1];
          item.value = {16'd0, s_byte, acc[7:0]};
        end
      end else if (pos_ext < crc_end) begin
        if (plen_eff <= 8'(PAYLOAD_MAX)) begin
          have_item  = 1'b1;
          item.kind  = KIND_PAYLOAD;
          item.index = pay_idx[7:0];
          item.value = {24'd0, s_byte};
        end
      end else if (pos_ext == crc_end) begin
        rcrc_next[7:0] = s_byte;
      end else if (pos_ext == crc_end + SUM_W'(1)) begin
        rcrc_next[15:8] = s_byte;
      end

      if (pos_ext < crc_end) begin
        crc_next = crc_byte(crc, s_byte);
      end
      if (pos != POS_W'(POS_SAT)) begin
        pos_next = pos + POS_W'(1);
      end

      if (s_fend) begin
        if (len < SUM_W'(HDR_BYTES + 2)) begin
          vcode = VERDICT_SHORT_HDR;
        end else if (plen_eff > 8'(PAYLOAD_MAX)) begin
          vcode = VERDICT_PLEN_BIG;
        end else if (pcnt_next > 8'(PATH_MAX)) begin
          vcode = VERDICT_PATH_BIG;
        end else if (len < crc_end + SUM_W'(2)) begin
          vcode = VERDICT_SHORT_PAY;
        end else if (rcrc_next != crc_next) begin
          vcode = VERDICT_CRC_BAD;
        end else begin
          vcode = VERDICT_OK;
        end
        vitem.kind    = KIND_VERDICT;
        vitem.verdict = vcode;
        vitem.last    = 1'b1;
        pos_next  = '0;
        crc_next  = CRC_INIT;
        acc_next  = '0;
        plen_next = '0;
        pcnt_next = '0;
        rcrc_next = '0;
      end
    end

    push = '0;
    if (have_item) begin
      push.v0 = 1'b1;
      push.r0 = item;
      push.v1 = s_valid & s_fend;
      push.r1 = vitem;
    end else begin
      push.v0 = s_valid & s_fend;
      push.r0 = vitem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      crc       <= CRC_INIT;
      acc       <= '0;
      plen_seen <= '0;
      pcnt_seen <= '0;
      rcrc      <= '0;
    end else begin
      pos       <= pos_next;
      crc       <= crc_next;
      acc       <= acc_next;
      plen_seen <= plen_next;
      pcnt_seen <= pcnt_next;
      rcrc      <= rcrc_next;
    end
  end

endmodule

// ===== rtl/mfp_out_fifo.sv =====
// Result queue: up to two words written per cycle, one word read per cycle.
module mfp_out_fifo
  import mfp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  push_t              push,
  output logic [FIFO_CW-1:0] count,
  output logic               item_valid,
  input  logic               item_ready,
  output result_t            head
);

  result_t            mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp, rp;
  logic               pop;
  logic [FIFO_CW-1:0] n_push;

  assign item_valid = (count != '0);
  assign head       = mem[rp];
  assign pop        = item_valid & item_ready;
  assign n_push     = FIFO_CW'(push.v0) + FIFO_CW'(push.v1);

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem[wp] <= push.r0;
    end
    if (push.v1) begin
      mem[wp + FIFO_AW'(1)] <= push.r1;
    end
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + n_push[FIFO_AW-1:0];
      if (pop) begin
        rp <= rp + FIFO_AW'(1);
      end
      count <= count + n_push - FIFO_CW'(pop);
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the mesh frame parser: frames in byte by byte, decoded words checked.
module testbench
  import mfp_pkg::*;
();

  localparam int PLEN_AT = 18;
  localparam int PCNT_AT = 19;
  localparam int STIM_BYTES = 1600;
  localparam int HOLD_CYCLES = 200;

  localparam result_t SHORT_HDR_END = {KIND_VERDICT, 8'd0, 32'd0, VERDICT_SHORT_HDR, 1'b1};

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_PLEN_BIG, FR_PATH_BIG, FR_TRUNC, FR_NOISE, FR_LONG}
    frame_flavor_t;

  typedef struct {
    logic [7:0] data;
    logic       fend;
    logic       typed;
    result_t    want;
  } drive_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        frame_end = 1'b0;
  logic        item_valid;
  logic        item_ready = 1'b0;
  logic [1:0]  item_kind;
  logic [7:0]  item_index;
  logic [31:0] item_value;
  logic [2:0]  verdict;
  logic        last_item;

  // testbench-side tag carried along with each byte
  logic        byte_typed = 1'b0;
  result_t     byte_want = '0;

  result_t     pending_words[$];
  int          mismatches = 0;
  bit          rx_hold_req = 1'b0;

  logic [7:0]  frame_q[$];
  int          frame_used;

  // decoder state
  logic [8:0]  rx_pos = '0;
  logic [15:0] dec_crc = CRC_INIT;
  logic [31:0] fld_acc = '0;
  logic [7:0]  plen_seen = '0;
  logic [7:0]  pcnt_seen = '0;
  logic [15:0] crc_got = '0;

  int field_start [13] = '{0, 4, 6, 8, 10, 12, 13, 14, 16, 17, 18, 19, 20};

  drive_row_t directed_rows [18] = '{
    '{8'h00, 1'b1, 1'b1, SHORT_HDR_END},
    '{8'hFF, 1'b1, 1'b1, SHORT_HDR_END},
    '{8'hA5, 1'b0, 1'b0, '0},
    '{8'h5A, 1'b0, 1'b0, '0},
    '{8'hC3, 1'b1, 1'b1, SHORT_HDR_END},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b0, 1'b1, {KIND_FIELD, 8'd0, 32'hFFFF_FFFF, VERDICT_OK, 1'b0}},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h80, 1'b0, 1'b1, {KIND_FIELD, 8'd1, 32'h0000_8000, VERDICT_OK, 1'b0}},
    '{8'h01, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b0, '0},
    '{8'h00, 1'b0, 1'b1, {KIND_FIELD, 8'd0, 32'h0000_0000, VERDICT_OK, 1'b0}},
    '{8'h7F, 1'b1, 1'b1, SHORT_HDR_END}
  };

  mesh_frame_parser_crc16_check_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item_kind  (item_kind),
    .item_index (item_index),
    .item_value (item_value),
    .verdict    (verdict),
    .last_item  (last_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] crc_next(input logic [15:0] c, input logic [7:0] b);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void push_word(input logic [1:0] kind, input logic [7:0] idx,
                                    input logic [31:0] val, input logic [2:0] v,
                                    input logic last);
    pending_words.push_back({kind, idx, val, v, last});
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic fend);
    int p;
    int pl;
    int len;
    int r;
    logic [2:0] v;
    p = rx_pos;
    pl = plen_seen;
    if (p < FIELD_BYTES) begin
      for (int f = 0; f < 12; f++) begin
        if (p >= field_start[f] && p < field_start[f + 1]) begin
          if (p == field_start[f]) fld_acc = '0;
          fld_acc = fld_acc | (32'(b) << (8 * (p - field_start[f])));
          if (p == field_start[f + 1] - 1) push_word(KIND_FIELD, 8'(f), fld_acc, VERDICT_OK, 1'b0);
        end
      end
      if (p == PLEN_AT) begin
        plen_seen = b;
        pl = b;
      end
      if (p == PCNT_AT) pcnt_seen = b;
    end else if (p < HDR_BYTES) begin
      r = p - FIELD_BYTES;
      if (r % 2 == 0) begin
        fld_acc = 32'(b);
      end else begin
        fld_acc = fld_acc | (32'(b) << 8);
        push_word(KIND_PATH, 8'(r / 2), {16'd0, fld_acc[15:0]}, VERDICT_OK, 1'b0);
      end
    end else if (p < HDR_BYTES + pl) begin
      if (pl <= PAYLOAD_MAX)
        push_word(KIND_PAYLOAD, 8'(p - HDR_BYTES), 32'(b), VERDICT_OK, 1'b0);
    end else if (p == HDR_BYTES + pl) begin
      crc_got[7:0] = b;
    end else if (p == HDR_BYTES + pl + 1) begin
      crc_got[15:8] = b;
    end
    if (p < HDR_BYTES + pl) dec_crc = crc_next(dec_crc, b);
    if (p < POS_SAT) rx_pos = 9'(p + 1);
    if (fend) begin
      len = p + 1;
      if (len < HDR_BYTES + 2) v = VERDICT_SHORT_HDR;
      else if (pl > PAYLOAD_MAX) v = VERDICT_PLEN_BIG;
      else if (pcnt_seen > PATH_MAX) v = VERDICT_PATH_BIG;
      else if (len < HDR_BYTES + pl + 2) v = VERDICT_SHORT_PAY;
      else if (crc_got != dec_crc) v = VERDICT_CRC_BAD;
      else v = VERDICT_OK;
      push_word(KIND_VERDICT, 8'd0, 32'd0, v, 1'b1);
      rx_pos = '0;
      dec_crc = CRC_INIT;
      fld_acc = '0;
      plen_seen = '0;
      pcnt_seen = '0;
      crc_got = '0;
    end
  endfunction

  function automatic void make_frame(input frame_flavor_t flavor);
    int plen;
    int pcnt;
    int full;
    int cut;
    int target;
    logic [15:0] c;
    logic [7:0] b;
    frame_q.delete();
    if (flavor == FR_NOISE) begin
      repeat ($urandom_range(1, 60)) frame_q.push_back(8'($urandom));
      frame_used = frame_q.size();
      return;
    end
    case ($urandom_range(0, 15))
      0: plen = PAYLOAD_MAX;
      1: plen = $urandom_range(0, PAYLOAD_MAX);
      default: plen = $urandom_range(0, 12);
    endcase
    if (flavor == FR_PLEN_BIG) plen = $urandom_range(PAYLOAD_MAX + 1, 255);
    if (flavor == FR_TRUNC && plen == 0) plen = $urandom_range(1, 12);
    pcnt = ($urandom_range(0, 3) == 0) ? PATH_MAX : $urandom_range(0, PATH_MAX);
    if (flavor == FR_PATH_BIG) pcnt = $urandom_range(PATH_MAX + 1, 255);
    c = CRC_INIT;
    for (int i = 0; i < HDR_BYTES + plen; i++) begin
      if (i == PLEN_AT) b = 8'(plen);
      else if (i == PCNT_AT) b = 8'(pcnt);
      else b = 8'($urandom);
      frame_q.push_back(b);
      c = crc_next(c, b);
    end
    if (flavor == FR_BAD_CRC) c = c ^ 16'(1 << $urandom_range(0, 15));
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
    full = frame_q.size();
    cut = full;
    if (flavor == FR_PLEN_BIG) cut = $urandom_range(HDR_BYTES + 2, full);
    if (flavor == FR_TRUNC) begin
      if ($urandom_range(0, 1) == 0) cut = $urandom_range(1, HDR_BYTES + 1);
      else cut = $urandom_range(HDR_BYTES + 2, full - 1);
    end
    while (frame_q.size() > cut) void'(frame_q.pop_back());
    // trailing bytes; long frames run the position counter into saturation
    if (flavor == FR_LONG) begin
      target = $urandom_range(513, 530);
      while (frame_q.size() < target) frame_q.push_back(8'($urandom));
    end else if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom));
    end
    frame_used = frame_q.size();
  endfunction

  function automatic int draw_wait();
    if ($urandom_range(0, 2) != 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic fend, input logic typed,
                           input result_t want, input int gap);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= b;
    frame_end  <= fend;
    byte_typed <= typed;
    byte_want  <= want;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // predict on accepted bytes, then check accepted words
  always @(posedge clk) begin : word_check
    result_t got;
    result_t want;
    if (!rst) begin
      if (byte_valid && byte_ready) begin
        decode_byte(data_byte, frame_end);
        if (byte_typed) pending_words[pending_words.size() - 1] = byte_want;
      end
      if (item_valid && item_ready) begin
        got = {item_kind, item_index, item_value, verdict, last_item};
        if (pending_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: kind %0d idx %0d val %h verdict %0d last %0b",
                     got.kind, got.index, got.value, got.verdict, got.last);
        end else begin
          want = pending_words.pop_front();
          if (got.kind !== want.kind || got.index !== want.index ||
              got.value !== want.value || got.verdict !== want.verdict ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp kind %0d idx %0d val %h verdict %0d last %0b, ",
                        "got kind %0d idx %0d val %h verdict %0d last %0b"},
                       want.kind, want.index, want.value, want.verdict, want.last,
                       got.kind, got.index, got.value, got.verdict, got.last);
          end
        end
      end
    end
  end

  initial begin : receiver
    int stall;
    int words;
    bit calm;
    words = 0;
    calm = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (words % 40 == 0) calm = ($urandom_range(0, 2) == 0);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        item_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        stall = calm ? 0 : draw_wait();
        if (stall > 0) begin
          item_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      item_ready <= 1'b1;
      @(posedge clk);
      while (!item_valid) @(posedge clk);
      words++;
    end
  end

  initial begin : stimulus
    int gap;
    int k;
    int n;
    int bytes_counted;
    bit burst;
    frame_flavor_t fl;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_byte(directed_rows[i].data, directed_rows[i].fend, directed_rows[i].typed,
                directed_rows[i].want, draw_wait());

    bytes_counted = 0;
    n = 0;
    while (bytes_counted < STIM_BYTES) begin
      k = $urandom_range(0, 99);
      if (n == 8 || n == 20) fl = FR_LONG;
      else if (k < 50) fl = FR_GOOD;
      else if (k < 60) fl = FR_BAD_CRC;
      else if (k < 68) fl = FR_PLEN_BIG;
      else if (k < 76) fl = FR_PATH_BIG;
      else if (k < 90) fl = FR_TRUNC;
      else fl = FR_NOISE;
      make_frame(fl);
      burst = ($urandom_range(0, 3) == 0);
      if (n == 5) begin
        rx_hold_req = 1'b1;
        burst = 1'b1;
      end
      foreach (frame_q[i]) begin
        gap = burst ? 0 : draw_wait();
        send_byte(frame_q[i], i == frame_q.size() - 1, 1'b0, '0, gap);
      end
      bytes_counted += frame_used;
      if (n == 3 || $urandom_range(0, 9) == 0) drain_results();
      n++;
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
